/* design/tcc_pkg.sv */
// shared constants, codes and helper functions for the thermistor converter
package tcc_pkg;

	// field and datapath widths
	localparam int ADC_BITS_DEF = 10;
	localparam int NUM_W        = 25;
	localparam int RES_W        = 20;
	localparam int OFS_W        = 16;
	localparam int COEF_W       = 48;
	localparam int PROD_W       = 40;
	localparam int EXP_W        = 6;
	localparam int MANT_W       = 31;
	localparam int FRAC_W       = 24;
	localparam int LOG_W        = EXP_W + FRAC_W;
	localparam int LN_W         = 30;
	localparam int MB_W         = 40;
	localparam int WIDE_W       = 64;
	localparam int DIV_W        = 63;
	localparam int QUO_W        = 40;
	localparam int DIFF_W       = 48;
	localparam int TEMP_W       = 16;

	// apb register map (64-bit registers at 8-byte spacing)
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam logic [2:0] REG_COEF_A     = 3'd0;
	localparam logic [2:0] REG_COEF_B     = 3'd1;
	localparam logic [2:0] REG_COEF_C     = 3'd2;
	localparam logic [2:0] REG_COEF_D     = 3'd3;
	localparam logic [2:0] REG_SERIES     = 3'd4;
	localparam logic [2:0] REG_REFERENCE  = 3'd5;
	localparam logic [2:0] REG_OFFSET     = 3'd6;
	localparam logic [2:0] REG_FULL_SCALE = 3'd7;

	// register reset values
	localparam logic [COEF_W-1:0] COEF_A_RST = 48'd3687779592;
	localparam logic [COEF_W-1:0] COEF_B_RST = 48'd282503568;
	localparam logic [COEF_W-1:0] COEF_C_RST = 48'd2887659;
	localparam logic [COEF_W-1:0] COEF_D_RST = 48'd74248;
	localparam logic [RES_W-1:0]  SERIES_RST = 20'd4700;
	localparam logic [RES_W-1:0]  REF_RST    = 20'd5000;
	localparam logic [OFS_W-1:0]  OFFSET_RST = 16'd864;
	localparam logic [RES_W-1:0]  FS_RST     = 20'd264371;

	// arithmetic constants
	localparam logic [31:0]        LN2_Q32    = 32'd2977044472;
	localparam logic [DIFF_W-1:0]  ZERO_C_Q16 = 48'd1790115840;
	localparam logic [DIFF_W-1:0]  CENTI      = 48'd100;
	localparam logic [WIDE_W-1:0]  KSAT_POLY  = 64'd65536;
	localparam logic [DIV_W-1:0]   DIV_INIT   = 63'd1 << (56 - QUO_W);

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_LOW  = 2'd1;
	localparam logic [1:0] ST_HIGH = 2'd2;
	localparam logic [1:0] ST_KSAT = 2'd3;

	// pipeline geometry
	localparam int LN_STEPS  = FRAC_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int MUL_LAT   = 4;
	localparam int S_CELL_IN = 5;
	localparam int S_LN_OUT  = S_CELL_IN + LN_STEPS;
	localparam int S_LN      = S_LN_OUT + 1;
	localparam int S_L       = S_LN + 1;
	localparam int S_MUL_OUT = S_L + 3 * MUL_LAT;
	localparam int S_SUM     = S_MUL_OUT + 1;
	localparam int S_POLY    = S_SUM + 1;
	localparam int S_DIVIN   = S_POLY + 1;
	localparam int S_DIVOUT  = S_DIVIN + DIV_STEPS;
	localparam int S_DIFF    = S_DIVOUT + 1;
	localparam int S_OUT     = S_DIFF + 1;

	// position of the highest set bit
	function automatic logic [EXP_W-1:0] lead_one(input logic [PROD_W-1:0] v);
		logic [EXP_W-1:0] e;
		e = '0;
		for (int i = 0; i < PROD_W; i++) begin
			if (v[i]) begin
				e = EXP_W'(i);
			end
		end
		return e;
	endfunction

	// scale a value into q.30 in [1,2) given its leading one position
	function automatic logic [MANT_W-1:0] norm_q30(input logic [PROD_W-1:0] v,
		input logic [EXP_W-1:0] e);
		logic [PROD_W-1:0] sh;
		if (e <= EXP_W'(30)) begin
			sh = v << (EXP_W'(30) - e);
		end else begin
			sh = v >> (e - EXP_W'(30));
		end
		return sh[MANT_W-1:0];
	endfunction

endpackage

/* design/tcc_ln_cell.sv */
// one log2 fraction cell: squares the mantissa and emits one fraction bit
module tcc_ln_cell (
	input  logic                        clk,
	input  logic [tcc_pkg::MANT_W-1:0]  m_in,
	input  logic [tcc_pkg::FRAC_W-1:0]  frac_in,
	output logic [tcc_pkg::MANT_W-1:0]  m_out,
	output logic [tcc_pkg::FRAC_W-1:0]  frac_out
);

	logic [2*tcc_pkg::MANT_W-1:0] sq;
	logic                         bit_one;
	logic [tcc_pkg::MANT_W-1:0]   m_next;
	logic [tcc_pkg::MANT_W-1:0]   m_s1;
	logic [tcc_pkg::FRAC_W-1:0]   frac_s1;

	// square in q.30, renormalize when it reaches two
	always_comb begin
		sq      = {{tcc_pkg::MANT_W{1'b0}}, m_in} * {{tcc_pkg::MANT_W{1'b0}}, m_in};
		bit_one = sq[2*tcc_pkg::MANT_W-1];
		if (bit_one) begin
			m_next = sq[2*tcc_pkg::MANT_W-1:tcc_pkg::MANT_W];
		end else begin
			m_next = sq[2*tcc_pkg::MANT_W-2:tcc_pkg::MANT_W-1];
		end
	end

	// hand the mantissa and fraction bits to the next cell
	always_ff @(posedge clk) begin
		m_s1    <= m_next;
		frac_s1 <= {frac_in[tcc_pkg::FRAC_W-2:0], bit_one};
	end

	assign m_out    = m_s1;
	assign frac_out = frac_s1;

endmodule

/* design/tcc_div_cell.sv */
// one restoring divider cell: one quotient bit per cell
module tcc_div_cell (
	input  logic                       clk,
	input  logic [tcc_pkg::DIV_W-1:0]  rem_in,
	input  logic [tcc_pkg::QUO_W-1:0]  quo_in,
	input  logic [tcc_pkg::DIV_W-1:0]  dvs_in,
	output logic [tcc_pkg::DIV_W-1:0]  rem_out,
	output logic [tcc_pkg::QUO_W-1:0]  quo_out,
	output logic [tcc_pkg::DIV_W-1:0]  dvs_out
);

	logic [tcc_pkg::DIV_W:0]   r2;
	logic [tcc_pkg::DIV_W:0]   rn;
	logic                      ge;
	logic [tcc_pkg::DIV_W-1:0] rem_s1;
	logic [tcc_pkg::QUO_W-1:0] quo_s1;
	logic [tcc_pkg::DIV_W-1:0] dvs_s1;

	// shift in a zero dividend bit, subtract when it fits
	always_comb begin
		r2 = {rem_in, 1'b0};
		ge = r2 >= {1'b0, dvs_in};
		rn = ge ? (r2 - {1'b0, dvs_in}) : r2;
	end

	always_ff @(posedge clk) begin
		rem_s1 <= rn[tcc_pkg::DIV_W-1:0];
		quo_s1 <= {quo_in[tcc_pkg::QUO_W-2:0], ge};
		dvs_s1 <= dvs_in;
	end

	assign rem_out = rem_s1;
	assign quo_out = quo_s1;
	assign dvs_out = dvs_s1;

endmodule

/* design/tcc_mulq24.sv */
// signed multiply scaled by 2^-24, truncated toward zero, four stages
module tcc_mulq24 (
	input  logic                               clk,
	input  logic signed [tcc_pkg::COEF_W-1:0]  a,
	input  logic signed [tcc_pkg::MB_W-1:0]    b,
	output logic signed [tcc_pkg::WIDE_W-1:0]  y
);

	logic                         neg_s1, neg_s2, neg_s3;
	logic [tcc_pkg::COEF_W-1:0]   ua_s1;
	logic [tcc_pkg::MB_W-1:0]     ub_s1;
	logic [39:0]                  pp_hh_s2;
	logic [47:0]                  pp_hl_s2;
	logic [39:0]                  pp_lh_s2;
	logic [47:0]                  pp_ll_s2;
	logic [tcc_pkg::WIDE_W-1:0]   sum_s3;
	logic signed [tcc_pkg::WIDE_W-1:0] y_s4;

	always_ff @(posedge clk) begin
		// magnitudes and sign
		neg_s1 <= a[tcc_pkg::COEF_W-1] ^ b[tcc_pkg::MB_W-1];
		ua_s1  <= a[tcc_pkg::COEF_W-1] ? tcc_pkg::COEF_W'(-a) : a;
		ub_s1  <= b[tcc_pkg::MB_W-1] ? tcc_pkg::MB_W'(-b) : b;
		// partial products of 24-bit halves
		neg_s2   <= neg_s1;
		pp_hh_s2 <= {16'b0, ua_s1[47:24]} * {24'b0, ub_s1[39:24]};
		pp_hl_s2 <= {24'b0, ua_s1[47:24]} * {24'b0, ub_s1[23:0]};
		pp_lh_s2 <= {16'b0, ua_s1[23:0]} * {24'b0, ub_s1[39:24]};
		pp_ll_s2 <= {24'b0, ua_s1[23:0]} * {24'b0, ub_s1[23:0]};
		// recombine, dropping the low 24 bits
		neg_s3 <= neg_s2;
		sum_s3 <= {pp_hh_s2, 24'b0} + {16'b0, pp_hl_s2} + {24'b0, pp_lh_s2}
			+ {40'b0, pp_ll_s2[47:24]};
		// restore sign
		y_s4 <= neg_s3 ? -$signed(sum_s3) : $signed(sum_s3);
	end

	assign y = y_s4;

endmodule

/* design/thermistor_code_to_celsius.sv */
// thermistor converter code to centi-degrees celsius, fully pipelined top level
// throughput: one code per cycle, busy stays low, results cannot be stalled
// depth is set by the two 24-cell log chains and the 40-cell divider chain
// reset clears the pipeline valid bits and loads the default register values
module thermistor_code_to_celsius #(
	parameter int ADC_BITS = tcc_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ADC_BITS-1:0]                 adc_code,
	output logic                                done,
	output logic signed [tcc_pkg::TEMP_W-1:0]   temp_centi_c,
	output logic                                out_of_range,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [tcc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [tcc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int LAT = tcc_pkg::S_OUT;
	localparam int NW  = tcc_pkg::NUM_W;
	localparam int RW  = tcc_pkg::RES_W;
	localparam int PW  = tcc_pkg::PROD_W;

	// configuration registers
	logic [tcc_pkg::COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [RW-1:0]              series_q, reference_q, full_scale_q;
	logic [tcc_pkg::OFS_W-1:0]  offset_q;
	logic                       cfg_wr;
	logic [2:0]                 cfg_idx;

	// pipeline
	logic                       vld_q [1:LAT-1];
	logic [1:0]                 st_q  [2:LAT-1];
	logic [1:0]                 st_div;
	logic [NW-1:0]              num_s1;
	logic [RW-1:0]              num20_s2, dif20_s2;
	logic [PW-1:0]              p_s3, q_s3, p_s4, q_s4;
	logic [tcc_pkg::EXP_W-1:0]  ep_s4, eq_s4;
	logic [tcc_pkg::EXP_W-1:0]  ep_q [tcc_pkg::S_CELL_IN:tcc_pkg::S_LN_OUT];
	logic [tcc_pkg::EXP_W-1:0]  eq_q [tcc_pkg::S_CELL_IN:tcc_pkg::S_LN_OUT];
	logic [tcc_pkg::MANT_W-1:0] cm_p [0:tcc_pkg::LN_STEPS];
	logic [tcc_pkg::MANT_W-1:0] cm_q [0:tcc_pkg::LN_STEPS];
	logic [tcc_pkg::FRAC_W-1:0] cf_p [0:tcc_pkg::LN_STEPS];
	logic [tcc_pkg::FRAC_W-1:0] cf_q [0:tcc_pkg::LN_STEPS];
	logic [2*32-3:0]            lnp_prod, lnq_prod;
	logic [tcc_pkg::LN_W-1:0]   lnp_s30, lnq_s30;
	logic signed [tcc_pkg::LN_W-1:0] l_s31;
	logic signed [tcc_pkg::LN_W-1:0] l_dly_q [0:2*tcc_pkg::MUL_LAT-1];
	logic signed [tcc_pkg::WIDE_W-1:0] l2_w, l3_w, bl_w, cl2_w, dl3_w;
	logic signed [tcc_pkg::WIDE_W-1:0] l2_dly_q [0:tcc_pkg::MUL_LAT-1];
	logic signed [tcc_pkg::WIDE_W-1:0] sum1_s44, sum2_s44, poly_s45;
	logic [tcc_pkg::DIV_W-1:0]  dr [0:tcc_pkg::DIV_STEPS];
	logic [tcc_pkg::DIV_W-1:0]  dd [0:tcc_pkg::DIV_STEPS];
	logic [tcc_pkg::QUO_W-1:0]  dq [0:tcc_pkg::DIV_STEPS];
	logic signed [tcc_pkg::DIFF_W-1:0] diff_s87;
	logic signed [tcc_pkg::DIFF_W-1:0] rnd;
	logic signed [31:0]         tt;
	logic signed [tcc_pkg::TEMP_W-1:0] tclamp;
	logic signed [tcc_pkg::TEMP_W-1:0] temp_q;
	logic                       oor_q;
	logic                       done_q;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// apb write transaction
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q     <= tcc_pkg::COEF_A_RST;
			coef_b_q     <= tcc_pkg::COEF_B_RST;
			coef_c_q     <= tcc_pkg::COEF_C_RST;
			coef_d_q     <= tcc_pkg::COEF_D_RST;
			series_q     <= tcc_pkg::SERIES_RST;
			reference_q  <= tcc_pkg::REF_RST;
			offset_q     <= tcc_pkg::OFFSET_RST;
			full_scale_q <= tcc_pkg::FS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tcc_pkg::REG_COEF_A:     coef_a_q     <= pwdata[tcc_pkg::COEF_W-1:0];
				tcc_pkg::REG_COEF_B:     coef_b_q     <= pwdata[tcc_pkg::COEF_W-1:0];
				tcc_pkg::REG_COEF_C:     coef_c_q     <= pwdata[tcc_pkg::COEF_W-1:0];
				tcc_pkg::REG_COEF_D:     coef_d_q     <= pwdata[tcc_pkg::COEF_W-1:0];
				tcc_pkg::REG_SERIES:     series_q     <= pwdata[RW-1:0];
				tcc_pkg::REG_REFERENCE:  reference_q  <= pwdata[RW-1:0];
				tcc_pkg::REG_OFFSET:     offset_q     <= pwdata[tcc_pkg::OFS_W-1:0];
				tcc_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[RW-1:0];
				default: begin
				end
			endcase
		end
	end

	// apb read data
	always_comb begin
		case (cfg_idx)
			tcc_pkg::REG_COEF_A:     prdata = {16'b0, coef_a_q};
			tcc_pkg::REG_COEF_B:     prdata = {16'b0, coef_b_q};
			tcc_pkg::REG_COEF_C:     prdata = {16'b0, coef_c_q};
			tcc_pkg::REG_COEF_D:     prdata = {16'b0, coef_d_q};
			tcc_pkg::REG_SERIES:     prdata = {44'b0, series_q};
			tcc_pkg::REG_REFERENCE:  prdata = {44'b0, reference_q};
			tcc_pkg::REG_OFFSET:     prdata = {48'b0, offset_q};
			tcc_pkg::REG_FULL_SCALE: prdata = {44'b0, full_scale_q};
			default:                 prdata = '0;
		endcase
	end

	// valid bits travel with each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k < LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[1] <= start && !busy;
			for (int k = 2; k < LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// status after the polynomial: non-positive or too small to divide
	always_comb begin
		st_div = st_q[tcc_pkg::S_POLY];
		if (st_q[tcc_pkg::S_POLY] == tcc_pkg::ST_OK) begin
			if (poly_s45 <= 0) begin
				st_div = tcc_pkg::ST_HIGH;
			end else if (poly_s45 <= $signed(tcc_pkg::KSAT_POLY)) begin
				st_div = tcc_pkg::ST_KSAT;
			end
		end
	end

	// status line, resolved early and again after the polynomial
	always_ff @(posedge clk) begin
		if (num_s1 >= NW'(full_scale_q) || reference_q == '0) begin
			st_q[2] <= tcc_pkg::ST_LOW;
		end else if (series_q == '0 || num_s1 == '0) begin
			st_q[2] <= tcc_pkg::ST_HIGH;
		end else begin
			st_q[2] <= tcc_pkg::ST_OK;
		end
		for (int k = 3; k < LAT; k++) begin
			st_q[k] <= (k == tcc_pkg::S_DIVIN) ? st_div : st_q[k-1];
		end
	end

	// front end: divider ratio terms, resistances, normalization
	always_ff @(posedge clk) begin
		num_s1   <= {{(NW - 8 - ADC_BITS){1'b0}}, adc_code, 8'b0} + NW'(offset_q);
		num20_s2 <= num_s1[RW-1:0];
		dif20_s2 <= full_scale_q - num_s1[RW-1:0];
		p_s3     <= {{(PW - RW){1'b0}}, series_q} * {{(PW - RW){1'b0}}, num20_s2};
		q_s3     <= {{(PW - RW){1'b0}}, reference_q} * {{(PW - RW){1'b0}}, dif20_s2};
		p_s4     <= p_s3;
		q_s4     <= q_s3;
		ep_s4    <= tcc_pkg::lead_one(p_s3);
		eq_s4    <= tcc_pkg::lead_one(q_s3);
		cm_p[0]  <= tcc_pkg::norm_q30(p_s4, ep_s4);
		cm_q[0]  <= tcc_pkg::norm_q30(q_s4, eq_s4);
		ep_q[tcc_pkg::S_CELL_IN] <= ep_s4;
		eq_q[tcc_pkg::S_CELL_IN] <= eq_s4;
		for (int k = tcc_pkg::S_CELL_IN + 1; k <= tcc_pkg::S_LN_OUT; k++) begin
			ep_q[k] <= ep_q[k-1];
			eq_q[k] <= eq_q[k-1];
		end
	end

	assign cf_p[0] = '0;
	assign cf_q[0] = '0;

	// log2 fraction chains
	for (genvar g = 0; g < tcc_pkg::LN_STEPS; g++) begin : g_ln
		tcc_ln_cell u_lnp (
			.clk      (clk),
			.m_in     (cm_p[g]),
			.frac_in  (cf_p[g]),
			.m_out    (cm_p[g+1]),
			.frac_out (cf_p[g+1])
		);
		tcc_ln_cell u_lnq (
			.clk      (clk),
			.m_in     (cm_q[g]),
			.frac_in  (cf_q[g]),
			.m_out    (cm_q[g+1]),
			.frac_out (cf_q[g+1])
		);
	end

	// log2 to natural log, then the log ratio
	assign lnp_prod = {32'b0, ep_q[tcc_pkg::S_LN_OUT], cf_p[tcc_pkg::LN_STEPS]}
		* {30'b0, tcc_pkg::LN2_Q32};
	assign lnq_prod = {32'b0, eq_q[tcc_pkg::S_LN_OUT], cf_q[tcc_pkg::LN_STEPS]}
		* {30'b0, tcc_pkg::LN2_Q32};

	always_ff @(posedge clk) begin
		lnp_s30 <= lnp_prod[61:32];
		lnq_s30 <= lnq_prod[61:32];
		l_s31   <= $signed(lnp_s30 - lnq_s30);
		l_dly_q[0] <= l_s31;
		for (int k = 1; k < 2 * tcc_pkg::MUL_LAT; k++) begin
			l_dly_q[k] <= l_dly_q[k-1];
		end
		l2_dly_q[0] <= l2_w;
		for (int k = 1; k < tcc_pkg::MUL_LAT; k++) begin
			l2_dly_q[k] <= l2_dly_q[k-1];
		end
	end

	// powers of the log ratio and the polynomial terms
	tcc_mulq24 u_l2 (
		.clk (clk),
		.a   (tcc_pkg::COEF_W'(l_s31)),
		.b   (tcc_pkg::MB_W'(l_s31)),
		.y   (l2_w)
	);

	tcc_mulq24 u_l3 (
		.clk (clk),
		.a   (l2_w[tcc_pkg::COEF_W-1:0]),
		.b   (tcc_pkg::MB_W'(l_dly_q[tcc_pkg::MUL_LAT-1])),
		.y   (l3_w)
	);

	tcc_mulq24 u_bl (
		.clk (clk),
		.a   ($signed(coef_b_q)),
		.b   (tcc_pkg::MB_W'(l_dly_q[2*tcc_pkg::MUL_LAT-1])),
		.y   (bl_w)
	);

	tcc_mulq24 u_cl2 (
		.clk (clk),
		.a   ($signed(coef_c_q)),
		.b   (l2_dly_q[tcc_pkg::MUL_LAT-1][tcc_pkg::MB_W-1:0]),
		.y   (cl2_w)
	);

	tcc_mulq24 u_dl3 (
		.clk (clk),
		.a   ($signed(coef_d_q)),
		.b   (l3_w[tcc_pkg::MB_W-1:0]),
		.y   (dl3_w)
	);

	// polynomial sum, divider load
	always_ff @(posedge clk) begin
		sum1_s44 <= tcc_pkg::WIDE_W'($signed(coef_a_q)) + bl_w;
		sum2_s44 <= cl2_w + dl3_w;
		poly_s45 <= sum1_s44 + sum2_s44;
		dd[0]    <= poly_s45[tcc_pkg::DIV_W-1:0];
	end

	assign dr[0] = tcc_pkg::DIV_INIT;
	assign dq[0] = '0;

	// reciprocal: kelvin in q.16 from 2^56 / poly
	for (genvar g = 0; g < tcc_pkg::DIV_STEPS; g++) begin : g_div
		tcc_div_cell u_div (
			.clk     (clk),
			.rem_in  (dr[g]),
			.quo_in  (dq[g]),
			.dvs_in  (dd[g]),
			.rem_out (dr[g+1]),
			.quo_out (dq[g+1]),
			.dvs_out (dd[g+1])
		);
	end

	// kelvin to centi-celsius, truncated toward zero and clamped
	always_comb begin
		rnd = diff_s87 + (diff_s87[tcc_pkg::DIFF_W-1] ? 48'sd65535 : 48'sd0);
		tt  = rnd[tcc_pkg::DIFF_W-1:16];
		if (tt > 32'sd32767) begin
			tclamp = 16'sh7fff;
		end else if (tt < -32'sd32768) begin
			tclamp = 16'sh8000;
		end else begin
			tclamp = tt[tcc_pkg::TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		diff_s87 <= $signed(tcc_pkg::DIFF_W'(dq[tcc_pkg::DIV_STEPS]) * tcc_pkg::CENTI
			- tcc_pkg::ZERO_C_Q16);
		case (st_q[tcc_pkg::S_DIFF])
			tcc_pkg::ST_OK: begin
				temp_q <= tclamp;
				oor_q  <= 1'b0;
			end
			tcc_pkg::ST_LOW: begin
				temp_q <= 16'sh8000;
				oor_q  <= 1'b1;
			end
			tcc_pkg::ST_HIGH: begin
				temp_q <= 16'sh7fff;
				oor_q  <= 1'b1;
			end
			tcc_pkg::ST_KSAT: begin
				temp_q <= 16'sh7fff;
				oor_q  <= 1'b0;
			end
			default: begin
				temp_q <= 16'sh7fff;
				oor_q  <= 1'b1;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[LAT-1];
		end
	end

	assign done         = done_q;
	assign temp_centi_c = temp_q;
	assign out_of_range = oor_q;

	// every accepted transaction gives exactly one result after the pipeline depth
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted code produced no result");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted code");

	// flagged results are always saturated
	a_flag_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> (temp_centi_c == 16'sh7fff || temp_centi_c == 16'sh8000))
		else $error("out of range result not saturated");

endmodule
